// File: design/ccs_pkg.sv
// Shared types and constants for the coulomb counter SOC estimator.
// No dependencies; imported by ccs_ctrl, ccs_dp and coulomb_counter_soc_top.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

  // SOC scale: full charge in hundredths of a percent
  localparam logic [13:0] SOC_FULL       = 14'd10000;
  localparam logic [13:0] INIT_SOC_RESET = 14'd10000;
  localparam logic [47:0] CAP_RESET      = 48'd36000000000;

  // quotient bits kept by the divider; anything wider is "far out of range"
  localparam int QUO_W     = 15;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  // configuration register indexes
  localparam logic CFG_INITIAL_SOC = 1'b0;
  localparam logic CFG_CAPACITY    = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_IN_RANGE = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_HOLD     = 2'd3;

  typedef struct packed {
    logic signed [15:0] current_ma;
    logic [31:0]        time_ms;
  } ccs_in_t;

  typedef struct packed {
    logic [13:0]        soc_hundredths;
    logic signed [47:0] charge_step;
    logic [1:0]         soc_status;
  } ccs_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture item, update last sample
    logic mul;    // trapezoid product
    logic step;   // halve toward zero
    logic acc;    // saturating accumulate
    logic mag;    // magnitude of accumulator
    logic plo;    // low half times 10000
    logic phi;    // high half times 10000
    logic sum;    // combine partial products
    logic chk;    // quotient overflow check, divider setup
    logic div;    // one restoring divide step
    logic fin;    // classify, update state, load result
  } ccs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic big;    // quotient too large for the divider
  } ccs_sts_t;

endpackage

`default_nettype wire

// File: design/ccs_ctrl.sv
// Sequencer for the coulomb counter: steps the datapath through one item.
// Depends on ccs_pkg for command/status structs and divider length.
`timescale 1ns / 1ps
`default_nettype none

module ccs_ctrl
  import ccs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output ccs_cmd_t      cmd,
  input  wire ccs_sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_STEP = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_MAG  = 4'd4;
  localparam logic [3:0] S_PLO  = 4'd5;
  localparam logic [3:0] S_PHI  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]           state, state_next;
  logic [DIV_CNT_W-1:0] count, count_next;
  logic                 out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    count_next     = count;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_PLO;
      end
      S_PLO: begin
        cmd.plo    = 1'b1;
        state_next = S_PHI;
      end
      S_PHI: begin
        cmd.phi    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        count_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.big) begin
          state_next = S_FIN;
        end else begin
          cmd.div    = 1'b1;
          count_next = count + 1'b1;
          if (count == DIV_LAST) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: design/ccs_dp.sv
// Datapath for the coulomb counter: trapezoid charge, accumulator,
// scaled restoring divider, SOC classification and result register.
// Depends on ccs_pkg; driven by ccs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ccs_dp
  import ccs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire ccs_in_t     in_item,
  input  wire ccs_cmd_t    cmd,
  output ccs_sts_t         sts,
  output ccs_out_t         out_item
);

  // configuration
  logic [13:0] start_soc;
  logic [47:0] cap;

  // item state
  logic signed [15:0] last_cur;
  logic [31:0]        last_time;
  logic signed [63:0] charge;
  logic [13:0]        soc_val;

  // working registers
  logic signed [16:0] cur_sum;
  logic [31:0]        dt;
  logic signed [48:0] prod;
  logic signed [47:0] step;
  logic               neg;
  logic [63:0]        mag;
  logic [45:0]        plo;
  logic [45:0]        phi;
  logic [77:0]        num;
  logic [47:0]        capx;
  logic [61:0]        dvsr;
  logic [QUO_W-1:0]   quo;
  logic               big;

  // combinational
  logic signed [49:0] prod_full;
  logic signed [48:0] prod_adj;
  logic signed [63:0] step_ext;
  logic signed [63:0] acc_sum;
  logic               acc_ovf;
  logic signed [63:0] acc_sat;
  logic [31:0]        mul_in;
  logic [45:0]        mul_out;
  logic               div_ge;
  logic signed [17:0] soc_calc;
  logic signed [17:0] init_s;
  logic signed [17:0] quo_s;
  logic signed [17:0] full_s;
  logic [1:0]         status;
  logic [13:0]        soc_val_next;

  assign sts.big = big;

  assign prod_full = cur_sum * $signed({1'b0, dt});
  // truncate toward zero: bias negatives by one before the shift
  assign prod_adj  = prod + $signed({48'd0, prod[48]});

  assign step_ext = {{16{step[47]}}, step};
  assign acc_sum  = charge + step_ext;
  assign acc_ovf  = (charge[63] == step_ext[63]) && (acc_sum[63] != charge[63]);
  assign acc_sat  = acc_ovf ? (charge[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_sum;

  // one 32x14 multiplier serves both halves of the magnitude
  assign mul_in  = cmd.phi ? mag[63:32] : mag[31:0];
  assign mul_out = mul_in * 46'(SOC_FULL);

  assign div_ge = (num[62:0] >= {1'b0, dvsr});

  assign init_s   = $signed({4'd0, start_soc});
  assign quo_s    = $signed({{(18 - QUO_W){1'b0}}, quo});
  assign full_s   = $signed({4'd0, SOC_FULL});
  assign soc_calc = neg ? (init_s + quo_s) : (init_s - quo_s);

  always_comb begin
    status       = STAT_HOLD;
    soc_val_next = soc_val;
    if (big) begin
      if (neg) begin
        status       = STAT_FULL;
        soc_val_next = SOC_FULL;
      end else begin
        status       = STAT_EMPTY;
        soc_val_next = '0;
      end
    end else if (soc_calc > 18'sd0 && soc_calc <= full_s) begin
      status       = STAT_IN_RANGE;
      soc_val_next = soc_calc[13:0];
    end else if (soc_calc < 18'sd0) begin
      status       = STAT_EMPTY;
      soc_val_next = '0;
    end else if (soc_calc > full_s) begin
      status       = STAT_FULL;
      soc_val_next = SOC_FULL;
    end
  end

  // configuration and item state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_soc <= INIT_SOC_RESET;
      cap       <= CAP_RESET;
      last_cur  <= '0;
      last_time <= '0;
      charge    <= '0;
      soc_val   <= INIT_SOC_RESET;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_INITIAL_SOC: start_soc <= cfg_data[13:0];
          CFG_CAPACITY:    cap       <= cfg_data;
          default:         cap       <= cap;
        endcase
      end
      if (cmd.load) begin
        last_cur  <= in_item.current_ma;
        last_time <= in_item.time_ms;
      end
      if (cmd.acc) begin
        charge <= acc_sat;
      end else if (cmd.fin) begin
        if (status == STAT_EMPTY) begin
          charge <= $signed({16'd0, capx});
        end else if (status == STAT_FULL) begin
          charge <= '0;
        end
      end
      if (cmd.fin) begin
        soc_val <= soc_val_next;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_sum <= 17'(last_cur) + 17'(in_item.current_ma);
      dt      <= in_item.time_ms - last_time;
    end
    if (cmd.mul) begin
      prod <= prod_full[48:0];
    end
    if (cmd.step) begin
      step <= prod_adj[48:1];
    end
    if (cmd.mag) begin
      neg <= charge[63];
      mag <= charge[63] ? (64'd0 - charge) : charge;
    end
    if (cmd.plo) begin
      plo <= mul_out;
    end
    if (cmd.phi) begin
      phi <= mul_out;
    end
    if (cmd.sum) begin
      num  <= {phi, 32'd0} + {32'd0, plo};
      capx <= (cap == '0) ? 48'd1 : cap;
    end
    if (cmd.chk) begin
      big  <= (num >= {15'd0, capx, 15'd0});
      dvsr <= {capx, 14'd0};
      quo  <= '0;
    end
    if (cmd.div) begin
      if (div_ge) begin
        num <= {15'd0, num[62:0] - {1'b0, dvsr}};
      end
      quo  <= {quo[QUO_W-2:0], div_ge};
      dvsr <= dvsr >> 1;
    end
    if (cmd.fin) begin
      out_item.soc_hundredths <= soc_val_next;
      out_item.charge_step    <= step;
      out_item.soc_status     <= status;
    end
  end

endmodule

`default_nettype wire

// File: design/coulomb_counter_soc_top.sv
// Coulomb counter SOC estimator: one item at a time runs the sequence below;
// the divide steps are skipped when the scaled quotient overflows.
// Cost is set by the 15-step restoring divider for charge*10000/capacity.
// A finished result sits in the output register; the next item may enter
// while it waits. Synchronous reset: SOC 100.00 %, capacity 36e9 uC,
// last sample, time and accumulator all zero.
`timescale 1ns / 1ps
`default_nettype none

module coulomb_counter_soc_top
  import ccs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data,
  // sample input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ccs_in_t     in_item,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output ccs_out_t         out_item
);

  // Sequence per item:
  //   load   - dt and current sum formed, last sample updated
  //   mul    - (prev + curr) * dt, 17 x 33 signed
  //   step   - halve, rounding toward zero
  //   acc    - saturating 64-bit accumulate
  //   mag    - |charge|, sign kept aside
  //   plo/phi- |charge| * 10000 as two 32 x 14 partial products
  //   sum    - 78-bit numerator
  //   chk    - numerator >= capacity << 15 means SOC is far out of range
  //   div    - 15 restoring steps, one quotient bit each
  //   fin    - clamp / hold decision, state update, result registered
  ccs_cmd_t cmd;
  ccs_sts_t sts;

  ccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ccs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_item      (in_item),
    .cmd          (cmd),
    .sts          (sts),
    .out_item     (out_item)
  );

endmodule

`default_nettype wire

// File: tb/coulomb_counter_soc_top_test.sv
// Self-checking bench for coulomb_counter_soc_top: directed corner samples, then random
// bursts under three idle patterns, each result checked against an in-bench SOC tracker.
// Depends on ccs_pkg and coulomb_counter_soc_top only.
`timescale 1ns / 1ps

import ccs_pkg::*;

// Tracks the estimator state and keeps the results still owed by the block.
class soc_tracker;
  ccs_out_t           soc_results_due[$];
  logic [13:0]        start_soc;
  logic [47:0]        capacity;
  logic signed [15:0] last_sample_ma;
  logic [31:0]        prev_stamp;
  longint             charge;
  logic [13:0]        soc_held;
  int                 errors;
  int                 accepted;
  int                 status_count[4];

  function new();
    start_soc      = INIT_SOC_RESET;
    capacity       = CAP_RESET;
    last_sample_ma = '0;
    prev_stamp     = '0;
    charge         = 0;
    soc_held       = INIT_SOC_RESET;
    errors         = 0;
    accepted       = 0;
    foreach (status_count[k]) status_count[k] = 0;
  endfunction

  // initial_soc writes never touch soc_held; only reset and sample updates load it
  function void write_reg(logic idx, logic [47:0] data);
    if (idx == CFG_INITIAL_SOC) start_soc = data[13:0];
    else capacity = data;
  endfunction

  function int pending();
    return soc_results_due.size();
  endfunction

  function void note_sample(ccs_in_t s);
    logic [31:0]        dt;
    logic signed [16:0] cur_sum;
    longint             step;
    longint             total;
    longint             soc;
    longint unsigned    cap;
    longint unsigned    mag;
    longint unsigned    quo;
    longint unsigned    rem;
    longint unsigned    scaled;
    logic [1:0]         status;
    ccs_out_t           r;
    dt      = s.time_ms - prev_stamp;
    cur_sum = $signed({last_sample_ma[15], last_sample_ma}) +
              $signed({s.current_ma[15], s.current_ma});
    // trapezoid, halved toward zero
    step = longint'(cur_sum) * longint'({32'd0, dt});
    step = step / 2;
    last_sample_ma = s.current_ma;
    prev_stamp     = s.time_ms;
    // saturating 64-bit accumulate
    total = charge + step;
    if (charge > 0 && step > 0 && total < 0) total = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (charge < 0 && step < 0 && total >= 0) total = 64'sh8000_0000_0000_0000;
    charge = total;
    cap = (capacity == '0) ? 64'd1 : {16'd0, capacity};
    mag = (charge < 0) ? 64'(-charge) : 64'(charge);
    quo = mag / cap;
    rem = mag % cap;
    if (quo >= 64'd1000000000) scaled = 64'd10000000000000;
    else scaled = quo * 64'd10000 + (rem * 64'd10000) / cap;
    if (charge < 0) soc = longint'(start_soc) + longint'(scaled);
    else soc = longint'(start_soc) - longint'(scaled);
    if (soc > 0 && soc <= longint'(SOC_FULL)) begin
      soc_held = 14'(soc);
      status   = STAT_IN_RANGE;
    end else if (soc < 0) begin
      soc_held = '0;
      charge   = longint'(cap);
      status   = STAT_EMPTY;
    end else if (soc > longint'(SOC_FULL)) begin
      soc_held = SOC_FULL;
      charge   = 0;
      status   = STAT_FULL;
    end else begin
      status = STAT_HOLD;
    end
    r.soc_hundredths = soc_held;
    r.charge_step    = 48'(step);
    r.soc_status     = status;
    soc_results_due.push_back(r);
    status_count[status]++;
    accepted++;
  endfunction

  function void check_result(ccs_out_t got);
    ccs_out_t want;
    if (soc_results_due.size() == 0) begin
      errors++;
      $display("%0t: result with none pending: soc %0d step %0d status %0d",
               $time, got.soc_hundredths, got.charge_step, got.soc_status);
      return;
    end
    want = soc_results_due.pop_front();
    if (got.soc_hundredths !== want.soc_hundredths) begin
      errors++;
      $display("%0t: soc_hundredths expected %0d, got %0d",
               $time, want.soc_hundredths, got.soc_hundredths);
    end
    if (got.charge_step !== want.charge_step) begin
      errors++;
      $display("%0t: charge_step expected %0d, got %0d",
               $time, want.charge_step, got.charge_step);
    end
    if (got.soc_status !== want.soc_status) begin
      errors++;
      $display("%0t: soc_status expected %0d, got %0d",
               $time, want.soc_status, got.soc_status);
    end
  endfunction
endclass

module coulomb_counter_soc_top_test;

  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD = 300;
  localparam int HOLD_ITEMS = 16;
  localparam int PHASE_ITEMS = 455;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic        cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  ccs_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  ccs_out_t    out_item;

  soc_tracker  tracker = new();

  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          hold_requests = 0;
  int          reg_writes = 0;
  logic [31:0] clock_ms;

  coulomb_counter_soc_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run (every item waiting out the longest
  // idle stretches plus the long hold-offs) stays well under a tenth of this.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall per cycle, or a long hold-off on request.
  // Requests are counted so that only this process owns the hold counter.
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // Every taken result goes to the tracker. Signals are sampled at the edge
  // before any nonblocking update lands, so this sees the handshake as the
  // block does.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) tracker.check_result(out_item);
  end

  // Offer one item, idling first at the sender's rate; returns on the edge
  // that takes it. Valid stays high so the next item can follow back to back.
  task automatic send_sample(logic signed [15:0] cur, logic [31:0] stamp);
    ccs_in_t s;
    s.current_ma = cur;
    s.time_ms    = stamp;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_sample(s);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Register writes only go in with the block idle.
  task automatic set_reg(logic idx, logic [47:0] data);
    wait_results_done();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tracker.write_reg(idx, data);
    reg_writes++;
  endtask

  // One burst of samples around a base current, with an optional new
  // configuration. Capacity is often sized to the burst so that the SOC
  // moves through its range instead of clamping at once.
  task automatic random_burst(int count);
    int                 base;
    int                 noise_span;
    int                 i;
    logic [31:0]        dt_span;
    logic [31:0]        dt;
    logic signed [15:0] cur;
    longint unsigned    cap;
    logic [47:0]        data;
    wait_results_done();
    base = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 3) == 0) base = base / 256;  // light load
    noise_span = 1 << $urandom_range(0, 12);
    dt_span    = 32'd1 << $urandom_range(0, 16);
    if ($urandom_range(0, 1)) begin
      data = 48'({$urandom, $urandom});
      case ($urandom_range(0, 5))
        0: data[13:0] = 14'd0;
        1: data[13:0] = SOC_FULL;
        2: data[13:0] = 14'($urandom_range(10001, 16383));
        default: data[13:0] = 14'($urandom_range(1, 10000));
      endcase
      if ($urandom_range(0, 1)) data[47:14] = '0;
      set_reg(CFG_INITIAL_SOC, data);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: cap = 64'd0;
        1: cap = 64'd1;
        2: cap = 64'hFFFF_FFFF_FFFF;
        3, 4: cap = {$urandom, $urandom} >> $urandom_range(16, 63);
        default: cap = longint'((base < 0 ? -base : base) + 1) * dt_span *
                       $urandom_range(20, 400);
      endcase
      set_reg(CFG_CAPACITY, 48'(cap));
    end
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: cur = 16'($urandom);
        1: cur = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: cur = 16'(base + int'($urandom_range(0, noise_span)) - noise_span / 2);
      endcase
      case ($urandom_range(0, 19))
        0: dt = 32'd0;
        1: dt = $urandom;  // long gap, often wraps the tick
        2, 3: dt = $urandom_range(1, 3);
        default: dt = $urandom_range(1, dt_span);
      endcase
      clock_ms = clock_ms + dt;
      send_sample(cur, clock_ms);
    end
  endtask

  initial begin : stimulus
    int phase;
    int target;
    int i;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_item      <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= CFG_INITIAL_SOC;
    cfg_data     <= '0;
    snd_idle_pct = 18;
    rcv_idle_pct = 58;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset configuration (100.00 %, 36e9 uC) ---
    send_sample(16'sh7FFF, 32'd0);             // first sample, zero elapsed time
    send_sample(16'sh7FFF, 32'd100000);        // full-scale discharge, SOC drops
    send_sample(-16'sd32767, 32'd100001);      // opposite currents cancel
    send_sample(16'sh8000, 32'd100002);        // odd product halves toward zero
    send_sample(16'sh8000, 32'hFFFF_FFFF);     // huge charge-in, clamps full
    send_sample(16'sd100, 32'd5);              // tick wraps past 2^32
    send_sample(16'sd0, 32'd6);                // small discharge, back in range

    // small capacity: empty clamp, then exactly zero held at 0 and at 3.28 %
    set_reg(CFG_CAPACITY, 48'd1000000);
    send_sample(16'sh7FFF, 32'd1006);
    send_sample(-16'sd32767, 32'd2000);
    send_sample(-16'sd1, 32'd2002);
    send_sample(16'sd16385, 32'd2006);

    // zero capacity acts as one; then an oversized quotient
    set_reg(CFG_CAPACITY, 48'd0);
    send_sample(16'sd0, 32'd2010);
    send_sample(16'sh8000, 32'd2012);
    send_sample(16'sh7FFF, 32'd2013);          // sum of -1 halves to zero
    send_sample(16'sh7FFF, 32'd102013);

    // widest capacity, initial SOC above full (upper data bits are junk)
    set_reg(CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
    set_reg(CFG_INITIAL_SOC, 48'hFFFF_FFFF_FFFF);
    send_sample(16'sd0, 32'd102013);
    // initial SOC of zero: held value must still be the old one
    set_reg(CFG_INITIAL_SOC, 48'hFFFF_FFFF_C000);
    send_sample(16'sd0, 32'd102014);
    send_sample(16'sh7FFF, 32'hF001_8E7E);
    // back to reset values; accumulator far above capacity, then 0.01 %
    set_reg(CFG_INITIAL_SOC, 48'(SOC_FULL));
    set_reg(CFG_CAPACITY, CAP_RESET);
    send_sample(16'sh8000, 32'hF001_8E7F);
    send_sample(16'sd0, 32'hF001_8E80);
    clock_ms = 32'hF001_8E80;

    // --- random: receiver-heavy idling, sender-heavy idling, then none ---
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 18; rcv_idle_pct = 58; end
        1: begin snd_idle_pct = 58; rcv_idle_pct = 18; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      // long receiver hold-off while the sender keeps offering items
      if (phase != 1) begin
        wait_results_done();
        hold_requests++;
        for (i = 0; i < HOLD_ITEMS; i++) begin
          clock_ms = clock_ms + 32'd250;
          send_sample(16'sd1500, clock_ms);
        end
      end
      target = tracker.accepted + PHASE_ITEMS;
      while (tracker.accepted < target) random_burst($urandom_range(10, 60));
    end

    wait_results_done();
    repeat (40) @(posedge clk);

    $display("Ran %0d samples with %0d register writes under three idle patterns.",
             tracker.accepted, reg_writes);
    $display("Outcomes: in range %0d, clamped empty %0d, clamped full %0d, held %0d.",
             tracker.status_count[STAT_IN_RANGE], tracker.status_count[STAT_EMPTY],
             tracker.status_count[STAT_FULL], tracker.status_count[STAT_HOLD]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
